FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, switched off while reset is high.
`define BMM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same assertion written as an overlapping implication.
`define BMM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   `BMM_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

FILE: design/bmm_pkg.sv
// Package with the types and constants of the bounded multiset unit.
`timescale 1ns / 1ps
`default_nettype none

package bmm_pkg;

   // Field widths.
   localparam int VALUE_W = 10;
   localparam int SLOT_W  = 9;
   localparam int COUNT_W = 9;

   // Highest reading that an add may store.
   localparam logic [VALUE_W-1:0] MAX_READING = 10'd400;

   // Operation codes carried on the input beat.
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Scan token that walks down the row of cells, one cell per cycle.
   typedef struct packed {
      logic              active;
      logic              found;
      logic              any;
      logic [SLOT_W-1:0] lo;
      logic [SLOT_W-1:0] hi;
   } bmm_token_type;

   // Signals the controller drives to every cell at once.
   typedef struct packed {
      logic               op_remove;
      logic [VALUE_W-1:0] value;
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_data;
      logic               compact;
   } bmm_bcast_type;

endpackage

`default_nettype wire

FILE: design/bmm_cell.sv
// One storage cell of the row: holds a reading and processes the scan token.
`timescale 1ns / 1ps
`default_nettype none

module bmm_cell
   import bmm_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 9
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bmm_bcast_type     bcast,
   input  wire logic [CNT_W-1:0]  bound,
   input  wire logic [CNT_W-1:0]  wr_idx,
   input  wire logic [SLOT_W-1:0] right_val,
   input  wire bmm_token_type     tok_in,
   output bmm_token_type          tok_out,
   output logic [SLOT_W-1:0]      val_out
);

   logic [SLOT_W-1:0] val_ff;
   logic [SLOT_W-1:0] val_in;
   logic              shift_ff;
   logic              shift_in;
   bmm_token_type     tok_ff;
   bmm_token_type     tok_in_nxt;
   logic              occupied;
   logic              match;
   logic              fold_en;

   // The cell holds a reading when its place is below the fill count.
   assign occupied = CNT_W'(INDEX) < bound;

   // The first occupied cell that equals the value on a remove is dropped.
   assign match   = bcast.op_remove && occupied && !tok_in.found
                    && ({1'b0, val_ff} == bcast.value);
   assign fold_en = occupied && !match;

   // Token update: fold this reading into the running min and max.
   always_comb begin
      tok_in_nxt       = tok_in;
      tok_in_nxt.found = tok_in.found | match;
      if (fold_en) begin
         tok_in_nxt.any = 1'b1;
         if (!tok_in.any) begin
            tok_in_nxt.lo = val_ff;
            tok_in_nxt.hi = val_ff;
         end else begin
            tok_in_nxt.lo = (val_ff < tok_in.lo) ? val_ff : tok_in.lo;
            tok_in_nxt.hi = (val_ff > tok_in.hi) ? val_ff : tok_in.hi;
         end
      end
   end

   // Cells at or after the removed reading take their neighbor's reading.
   always_comb begin
      shift_in = shift_ff;
      if (tok_in.active) begin
         shift_in = tok_in.found | match;
      end
      val_in = val_ff;
      if (bcast.wr_en && (wr_idx == CNT_W'(INDEX))) begin
         val_in = bcast.wr_data;
      end else if (bcast.compact && shift_ff) begin
         val_in = right_val;
      end
   end

   // Reading storage; its content is meaningful only below the fill count.
   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   // Token stage and shift flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         shift_ff <= 1'b0;
      end else begin
         tok_ff   <= tok_in_nxt;
         shift_ff <= shift_in;
      end
   end

   assign tok_out = tok_ff;
   assign val_out = val_ff;

endmodule

`default_nettype wire

FILE: design/bounded_multiset_min_max_unit.sv
// Top level of the bounded multiset unit: controller and row of cells.
//
// Usage: each input beat on req_ carries one operation. req_tuser is the
// operation (0 adds the reading, 1 removes one instance of it) and
// req_tdata holds the reading. Each input beat gives exactly one result
// beat on rsp_ with the accept flag, the count, the empty flag and the
// smallest and largest held readings (both zero when the store is empty).
// Readings live in a row of CAPACITY cells. A scan token enters the first
// cell and moves one cell per cycle, folding min and max and finding the
// reading to remove; a remove then shifts the later cells down by one.
// An operation passes the states IDLE, SEED, SCAN and DONE; the result
// beat is registered in DONE once the token has left the last cell. No new
// operation is taken until the token walk through the row is done.
// The next input beat is taken while a result still waits on rsp_.
// Reset empties the store and drops any pending result; no clearing pass
// is needed. When the receiver stalls, the result holds on rsp_tdata and
// at most one further operation completes into its holding register.
`timescale 1ns / 1ps
`default_nettype none

module bounded_multiset_min_max_unit
   import bmm_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // value[9:0]; zero fill above
   input  wire logic        req_tuser,  // op[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata   // accepted[0], count[9:1], empty_res[10],
                                        // smallest[19:11], largest[28:20]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic               op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               acc_ff, acc_in;
   logic [SLOT_W-1:0]  lo_ff, lo_in;
   logic [SLOT_W-1:0]  hi_ff, hi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               add_ok;
   logic               compact;
   bmm_bcast_type      bcast;
   bmm_token_type      tok [CAPACITY+1];
   logic [SLOT_W-1:0]  vals [CAPACITY];
   bmm_token_type      last_tok;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign add_ok     = (req_tuser == OP_ADD) && (req_tdata[VALUE_W-1:0] <= MAX_READING)
                       && (held_ff < CNT_W'(CAPACITY));
   assign last_tok   = tok[CAPACITY];
   assign compact    = (state_ff == ST_SCAN) && last_tok.active
                       && (op_ff == OP_REMOVE) && last_tok.found;

   // Broadcast to the cells; an add writes the cell at the fill count.
   always_comb begin
      bcast.op_remove = (op_ff == OP_REMOVE);
      bcast.value     = value_ff;
      bcast.wr_en     = accept && add_ok;
      bcast.wr_data   = req_tdata[SLOT_W-1:0];
      bcast.compact   = compact;
   end

   // Seed token enters the first cell for one cycle.
   always_comb begin
      tok[0]        = '0;
      tok[0].active = (state_ff == ST_SEED);
   end

   // Row of cells, each handing its token to the next.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [SLOT_W-1:0] right_val;
      if (i == CAPACITY - 1) begin : g_end
         assign right_val = vals[i];
      end else begin : g_mid
         assign right_val = vals[i+1];
      end
      bmm_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .bcast     (bcast),
         .bound     (held_ff),
         .wr_idx    (held_ff),
         .right_val (right_val),
         .tok_in    (tok[i]),
         .tok_out   (tok[i+1]),
         .val_out   (vals[i])
      );
   end

   // Controller next-state logic.
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      acc_in       = acc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_tuser;
               value_in = req_tdata[VALUE_W-1:0];
               acc_in   = add_ok;
               if (add_ok) begin
                  held_in = held_ff + 1'b1;
               end
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_tok.active) begin
               lo_in = last_tok.lo;
               hi_in = last_tok.hi;
               if (compact) begin
                  held_in = held_ff - 1'b1;
                  acc_in  = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, hi_ff, lo_ff, (held_ff == '0),
                               COUNT_W'(held_ff), acc_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Controller state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      value_ff    <= value_in;
      acc_ff      <= acc_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: design/bmm_checker.sv
// Port checker for the bounded multiset unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bmm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // A stalled result beat stays and holds its data.
   `BMM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")

   // An empty store reports a zero count and zero min and max.
   `BMM_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_tvalid && rsp_tdata[10], (rsp_tdata[9:1] == 9'd0) && (rsp_tdata[28:11] == 18'd0), "empty result with nonzero fields")

   // A nonempty store never reports min above max.
   `BMM_ASSERT_IMPL(a_min_le_max, clock, reset, rsp_tvalid && !rsp_tdata[10], rsp_tdata[19:11] <= rsp_tdata[28:20], "smallest above largest")

   // The block takes one operation at a time.
   `BMM_ASSERT_IMPL(a_busy_after_accept, clock, reset, req_tvalid && req_tready, ##1 !req_tready, "input taken while busy")

endmodule

bind bounded_multiset_min_max_unit bmm_checker u_bmm_checker (.*);

`default_nettype wire
